>>> design/led_two_phase_animator_defines.svh
// Assertion macros for the two-phase LED animator.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef LED_TWO_PHASE_ANIMATOR_DEFINES_SVH
`define LED_TWO_PHASE_ANIMATOR_DEFINES_SVH

// Implication in the same cycle.
`define TPA_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication in the next cycle.
`define TPA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/tpa_pkg.sv
// Shared types and constants of the two-phase LED animator.
// No dependencies; imported by every module of the block.
package tpa_pkg;

    localparam int CHANNELS  = 4;
    localparam int CH_W      = 2;
    localparam int IN_CH_W   = 3;
    localparam int COLOR_W   = 3;
    localparam int DUR_W     = 16;
    localparam int OP_W      = 2;
    localparam int MAX_RES   = 4;
    localparam int RES_CNT_W = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_ANIM  = 2'd1,
        OP_TICK  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic                 in_range;
        logic [IN_CH_W-1:0]   channel;
        logic [COLOR_W-1:0]   color_a;
        logic [DUR_W-1:0]     dur_a;
        logic [COLOR_W-1:0]   color_b;
        logic [DUR_W-1:0]     dur_b;
        logic [DUR_W-1:0]     cycles;
    } t_cmd;

    typedef struct packed {
        logic            ticking;
        logic [CH_W-1:0] sweep_idx;
    } t_bk_stat;

endpackage

>>> design/tpa_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on tpa_pkg.
module tpa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tpa_pkg::OP_W-1:0]      i_opcode,
    input  logic [tpa_pkg::IN_CH_W-1:0]   i_channel,
    input  logic [tpa_pkg::COLOR_W-1:0]   i_color_a,
    input  logic [tpa_pkg::DUR_W-1:0]     i_duration_a,
    input  logic [tpa_pkg::COLOR_W-1:0]   i_color_b,
    input  logic [tpa_pkg::DUR_W-1:0]     i_duration_b,
    input  logic [tpa_pkg::DUR_W-1:0]     i_cycle_count,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready,
    output tpa_pkg::t_cmd                 o_cmd
);
    import tpa_pkg::*;

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_CNT_W-1:0] n_cnt;
    t_cmd               cls;
    logic               push;
    logic               pop;

    always_comb begin
        cls.op       = t_op'(i_opcode);
        cls.in_range = ({1'b0, i_channel} < (IN_CH_W + 1)'(CHANNELS));
        cls.channel  = i_channel;
        cls.color_a  = i_color_a;
        cls.dur_a    = i_duration_a;
        cls.color_b  = i_color_b;
        cls.dur_b    = i_duration_b;
        cls.cycles   = i_cycle_count;
    end

    assign o_in_ready  = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

>>> design/tpa_back.sv
// Back end: per-channel animation state, command execution, tick sweep and output register.
// Depends on tpa_pkg.
module tpa_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  tpa_pkg::t_cmd                 i_cmd,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tpa_pkg::CH_W-1:0]      o_out_channel,
    output logic [tpa_pkg::COLOR_W-1:0]   o_out_color,
    output logic                          o_busy_res,
    output logic                          o_last,
    output tpa_pkg::t_bk_stat             o_stat
);
    import tpa_pkg::*;

    typedef enum logic {S_IDLE, S_TICK} t_state;

    t_state               r_state;
    logic [CH_W-1:0]      r_idx;
    logic [CHANNELS-1:0]  r_emit;
    logic [RES_CNT_W-1:0] r_n;

    logic [COLOR_W-1:0]   r_fc    [CHANNELS];
    logic [COLOR_W-1:0]   r_sc    [CHANNELS];
    logic [DUR_W-1:0]     r_fl    [CHANNELS];
    logic [DUR_W-1:0]     r_sl    [CHANNELS];
    logic [DUR_W-1:0]     r_cyc   [CHANNELS];
    logic                 r_sec   [CHANNELS];
    logic                 r_anim  [CHANNELS];
    logic [DUR_W-1:0]     r_ms    [CHANNELS];
    logic [COLOR_W-1:0]   r_shown [CHANNELS];

    logic                 r_ov;
    logic [CH_W-1:0]      r_och;
    logic [COLOR_W-1:0]   r_ocol;
    logic                 r_obusy;
    logic                 r_olast;

    logic                 out_free;
    logic                 out_load;
    logic                 cmd_take;
    logic                 sweep_go;
    logic [CH_W-1:0]      cmd_ch;
    logic                 anim_run;
    logic [CHANNELS-1:0]  due_mask;
    logic [DUR_W-1:0]     sw_ms_dec;
    logic                 sw_due;
    logic                 sw_stop;
    logic                 sw_emit;
    logic                 sw_later;
    logic                 sw_last;
    logic [COLOR_W-1:0]   sw_color;

    assign out_free    = !r_ov || i_out_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign cmd_take    = o_cmd_ready && i_cmd_valid;
    assign sweep_go    = (r_state == S_TICK) && out_free;
    assign cmd_ch      = i_cmd.channel[CH_W-1:0];
    assign anim_run    = (i_cmd.dur_a != '0) || (i_cmd.dur_b != '0);

    // The output register takes a new result in this cycle.
    assign out_load = (cmd_take && ((i_cmd.op == OP_QUERY) ||
                                    ((i_cmd.op != OP_TICK) && i_cmd.in_range)))
                      || (sweep_go && sw_emit);

    // A channel gives a result on this tick when its phase runs out and the
    // animation does not finish with the end of the second phase.
    always_comb begin
        for (int j = 0; j < CHANNELS; j++) begin
            due_mask[j] = r_anim[j] && (r_ms[j] <= DUR_W'(1))
                          && !(r_sec[j] && (r_cyc[j] == DUR_W'(1)));
        end
    end

    always_comb begin
        sw_ms_dec = (r_ms[r_idx] == '0) ? '0 : r_ms[r_idx] - 1'b1;
        sw_due    = r_anim[r_idx] && (r_ms[r_idx] <= DUR_W'(1));
        sw_stop   = r_sec[r_idx] && (r_cyc[r_idx] == DUR_W'(1));
        sw_emit   = r_emit[r_idx] && (r_n < RES_CNT_W'(MAX_RES));
        sw_color  = r_sec[r_idx] ? r_fc[r_idx] : r_sc[r_idx];
        sw_later  = 1'b0;
        for (int j = 0; j < CHANNELS; j++) begin
            if (j > int'(r_idx)) begin
                sw_later = sw_later | r_emit[j];
            end
        end
        sw_last = !sw_later || (r_n == RES_CNT_W'(MAX_RES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_emit  <= '0;
            r_n     <= '0;
            r_ov    <= 1'b0;
            for (int j = 0; j < CHANNELS; j++) begin
                r_fc[j]    <= '0;
                r_sc[j]    <= '0;
                r_fl[j]    <= '0;
                r_sl[j]    <= '0;
                r_cyc[j]   <= '0;
                r_sec[j]   <= 1'b0;
                r_anim[j]  <= 1'b0;
                r_ms[j]    <= '0;
                r_shown[j] <= '0;
            end
        end else begin
            if (r_ov && i_out_ready && !out_load) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cmd_take) begin
                        case (i_cmd.op)
                            OP_SET: begin
                                if (i_cmd.in_range) begin
                                    r_anim[cmd_ch]  <= 1'b0;
                                    r_ms[cmd_ch]    <= '0;
                                    r_shown[cmd_ch] <= i_cmd.color_a;
                                    r_ov    <= 1'b1;
                                    r_och   <= cmd_ch;
                                    r_ocol  <= i_cmd.color_a;
                                    r_obusy <= 1'b0;
                                    r_olast <= 1'b1;
                                end
                            end
                            OP_ANIM: begin
                                if (i_cmd.in_range) begin
                                    r_fc[cmd_ch]    <= i_cmd.color_a;
                                    r_sc[cmd_ch]    <= i_cmd.color_b;
                                    r_fl[cmd_ch]    <= i_cmd.dur_a;
                                    r_sl[cmd_ch]    <= i_cmd.dur_b;
                                    r_cyc[cmd_ch]   <= i_cmd.cycles;
                                    r_sec[cmd_ch]   <= 1'b0;
                                    r_anim[cmd_ch]  <= anim_run;
                                    r_ms[cmd_ch]    <= i_cmd.dur_a;
                                    r_shown[cmd_ch] <= i_cmd.color_a;
                                    r_ov    <= 1'b1;
                                    r_och   <= cmd_ch;
                                    r_ocol  <= i_cmd.color_a;
                                    r_obusy <= anim_run;
                                    r_olast <= 1'b1;
                                end
                            end
                            OP_QUERY: begin
                                r_ov    <= 1'b1;
                                r_och   <= cmd_ch;
                                r_ocol  <= i_cmd.in_range ? r_shown[cmd_ch] : '0;
                                r_obusy <= i_cmd.in_range && r_anim[cmd_ch];
                                r_olast <= 1'b1;
                            end
                            OP_TICK: begin
                                r_emit  <= due_mask;
                                r_idx   <= '0;
                                r_n     <= '0;
                                r_state <= S_TICK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_TICK: begin
                    if (sweep_go) begin
                        if (r_anim[r_idx]) begin
                            if (sw_due) begin
                                if (!r_sec[r_idx]) begin
                                    r_sec[r_idx]   <= 1'b1;
                                    r_shown[r_idx] <= r_sc[r_idx];
                                    r_ms[r_idx]    <= r_sl[r_idx];
                                end else if (sw_stop) begin
                                    // Last cycle done: stop and keep the second color.
                                    r_cyc[r_idx]  <= '0;
                                    r_anim[r_idx] <= 1'b0;
                                    r_ms[r_idx]   <= '0;
                                end else begin
                                    if (r_cyc[r_idx] != '0) begin
                                        r_cyc[r_idx] <= r_cyc[r_idx] - 1'b1;
                                    end
                                    r_sec[r_idx]   <= 1'b0;
                                    r_shown[r_idx] <= r_fc[r_idx];
                                    r_ms[r_idx]    <= r_fl[r_idx];
                                end
                            end else begin
                                r_ms[r_idx] <= sw_ms_dec;
                            end
                        end
                        if (sw_emit) begin
                            r_ov    <= 1'b1;
                            r_och   <= r_idx;
                            r_ocol  <= sw_color;
                            r_obusy <= 1'b1;
                            r_olast <= sw_last;
                            r_n     <= r_n + 1'b1;
                        end
                        if (r_idx == CH_W'(CHANNELS - 1)) begin
                            r_idx   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_ov;
    assign o_out_channel    = r_och;
    assign o_out_color      = r_ocol;
    assign o_busy_res       = r_obusy;
    assign o_last           = r_olast;
    assign o_stat.ticking   = (r_state == S_TICK);
    assign o_stat.sweep_idx = r_idx;

endmodule

>>> design/led_two_phase_animator.sv
// Two-phase LED animator, top level: connects front end and back end.
// Depends on tpa_pkg, tpa_front, tpa_back and led_two_phase_animator_defines.svh.
//
// Usage: each request on the input channel (i_in_valid / o_in_ready) is one
// command: set colour, start animation, one-millisecond tick or query. Results
// leave on the output channel (o_out_valid / i_out_ready); o_last marks the
// final result of a request, and a request may give none.
// Set, start and query are executed when the back end takes them; their result
// is written into the output register, which drives the output channel.
// A tick sweeps the channels one per cycle while the output register is free,
// and the back end takes no other command until the sweep is done.
// A two-entry queue sits between the front and back end, so requests are
// still taken while the back end sweeps, until the queue is full.
// A stalled receiver holds the output register; the back end then waits, and
// the queue fills and drops o_in_ready.
// Synchronous reset clears every channel to off and not running, and empties
// the queue and the output register.
`include "led_two_phase_animator_defines.svh"

module led_two_phase_animator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tpa_pkg::OP_W-1:0]      i_opcode,
    input  logic [tpa_pkg::IN_CH_W-1:0]   i_channel,
    input  logic [tpa_pkg::COLOR_W-1:0]   i_color_a,
    input  logic [tpa_pkg::DUR_W-1:0]     i_duration_a,
    input  logic [tpa_pkg::COLOR_W-1:0]   i_color_b,
    input  logic [tpa_pkg::DUR_W-1:0]     i_duration_b,
    input  logic [tpa_pkg::DUR_W-1:0]     i_cycle_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tpa_pkg::CH_W-1:0]      o_out_channel,
    output logic [tpa_pkg::COLOR_W-1:0]   o_out_color,
    output logic                          o_busy_res,
    output logic                          o_last
);
    import tpa_pkg::*;

    logic      cmd_valid;
    logic      cmd_ready;
    t_cmd      cmd;
    t_bk_stat  bk_stat;

    tpa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_channel    (i_channel),
        .i_color_a    (i_color_a),
        .i_duration_a (i_duration_a),
        .i_color_b    (i_color_b),
        .i_duration_b (i_duration_b),
        .i_cycle_count(i_cycle_count),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd        (cmd)
    );

    tpa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_ready  (cmd_ready),
        .i_cmd        (cmd),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_channel(o_out_channel),
        .o_out_color  (o_out_color),
        .o_busy_res   (o_busy_res),
        .o_last       (o_last),
        .o_stat       (bk_stat)
    );

    // An accepted request is always waiting in the queue in the next cycle.
    `TPA_ASSERT_NEXT(a_queue_holds, i_in_valid && o_in_ready, cmd_valid, "request lost in queue")
    // Only a tick sweep can leave a result that is not the last of its request.
    `TPA_ASSERT_SAME(a_partial_in_sweep, o_out_valid && !o_last, bk_stat.ticking, "stray partial result")
    // A sweep starts only from a command handed over by the front end.
    `TPA_ASSERT_SAME(a_sweep_start, $rose(bk_stat.ticking), $past(cmd_valid && cmd_ready), "sweep without command")
    // Between sweeps the channel index rests at zero.
    `TPA_ASSERT_SAME(a_idx_rest, !bk_stat.ticking, bk_stat.sweep_idx == '0, "sweep index not at rest")

endmodule

>>> dv/tb_led_two_phase_animator.sv
// Self-checking testbench for the two-phase LED animator: directed and random requests.
// A scoreboard class predicts every result; depends on tpa_pkg and led_two_phase_animator.
module tb_led_two_phase_animator;
    import tpa_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_ITEMS = 45;

    typedef struct packed {
        t_op                op;
        logic [IN_CH_W-1:0] channel;
        logic [COLOR_W-1:0] color_a;
        logic [DUR_W-1:0]   duration_a;
        logic [COLOR_W-1:0] color_b;
        logic [DUR_W-1:0]   duration_b;
        logic [DUR_W-1:0]   cycle_count;
    } t_led_request;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [COLOR_W-1:0] color;
        logic               busy;
        logic               last;
    } t_led_result;

    class animator_scoreboard;
        logic [COLOR_W-1:0] phase_a_color[CHANNELS];
        logic [COLOR_W-1:0] phase_b_color[CHANNELS];
        logic [DUR_W-1:0]   phase_a_len[CHANNELS];
        logic [DUR_W-1:0]   phase_b_len[CHANNELS];
        logic [DUR_W-1:0]   loops_to_go[CHANNELS];
        logic [DUR_W-1:0]   ms_left[CHANNELS];
        logic [COLOR_W-1:0] lit_color[CHANNELS];
        bit                 in_phase_b[CHANNELS];
        bit                 running[CHANNELS];
        t_led_result        colour_updates_q[$];
        int                 mismatches;

        function new();
            for (int i = 0; i < CHANNELS; i++) begin
                phase_a_color[i] = '0;
                phase_b_color[i] = '0;
                phase_a_len[i]   = '0;
                phase_b_len[i]   = '0;
                loops_to_go[i]   = '0;
                ms_left[i]       = '0;
                lit_color[i]     = '0;
                in_phase_b[i]    = 1'b0;
                running[i]       = 1'b0;
            end
            mismatches = 0;
        endfunction

        function int pending();
            return colour_updates_q.size();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%s", msg);
            end
        endfunction

        function void enter_phase(int ch, bit phase_b);
            in_phase_b[ch] = phase_b;
            lit_color[ch]  = phase_b ? phase_b_color[ch] : phase_a_color[ch];
            ms_left[ch]    = phase_b ? phase_b_len[ch] : phase_a_len[ch];
        endfunction

        // Returns 1 when the end of a phase puts a new colour on the LED; the
        // last counted cycle stops the channel on its second colour instead.
        function bit end_phase(int ch);
            if (!in_phase_b[ch]) begin
                enter_phase(ch, 1'b1);
                return 1'b1;
            end
            if (loops_to_go[ch] != 0) begin
                loops_to_go[ch] = loops_to_go[ch] - 1'b1;
                if (loops_to_go[ch] == 0) begin
                    running[ch] = 1'b0;
                    ms_left[ch] = '0;
                    return 1'b0;
                end
            end
            enter_phase(ch, 1'b0);
            return 1'b1;
        endfunction

        function t_led_result make_result(int ch, logic [COLOR_W-1:0] color, logic busy);
            t_led_result res;
            res.channel = CH_W'(ch);
            res.color   = color;
            res.busy    = busy;
            res.last    = 1'b0;
            return res;
        endfunction

        function void note_request(t_led_request req);
            t_led_result step_q[$];
            int          ch;
            bit          due;
            ch = int'(req.channel);
            case (req.op)
                OP_SET: begin
                    if (ch < CHANNELS) begin
                        running[ch]   = 1'b0;
                        ms_left[ch]   = '0;
                        lit_color[ch] = req.color_a;
                        step_q.push_back(make_result(ch, req.color_a, 1'b0));
                    end
                end
                OP_ANIM: begin
                    if (ch < CHANNELS) begin
                        phase_a_color[ch] = req.color_a;
                        phase_b_color[ch] = req.color_b;
                        phase_a_len[ch]   = req.duration_a;
                        phase_b_len[ch]   = req.duration_b;
                        loops_to_go[ch]   = req.cycle_count;
                        running[ch]       = 1'b1;
                        enter_phase(ch, 1'b0);
                        if (req.duration_a == 0 && req.duration_b == 0) begin
                            running[ch] = 1'b0;
                        end
                        step_q.push_back(make_result(ch, lit_color[ch], running[ch]));
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (running[i]) begin
                            // A stopped timer means a zero-length phase, due now.
                            if (ms_left[i] == 0) begin
                                due = 1'b1;
                            end else begin
                                ms_left[i] = ms_left[i] - 1'b1;
                                due = (ms_left[i] == 0);
                            end
                            if (due) begin
                                if (end_phase(i) && step_q.size() < MAX_RES) begin
                                    step_q.push_back(make_result(i, lit_color[i], running[i]));
                                end
                            end
                        end
                    end
                end
                default: begin
                    if (ch < CHANNELS) begin
                        step_q.push_back(make_result(ch, lit_color[ch], running[ch]));
                    end else begin
                        step_q.push_back(make_result(ch, '0, 1'b0));
                    end
                end
            endcase
            if (step_q.size() > 0) begin
                step_q[step_q.size() - 1].last = 1'b1;
            end
            foreach (step_q[k]) begin
                colour_updates_q.push_back(step_q[k]);
            end
        endfunction

        function void check_result(t_led_result got);
            t_led_result want;
            if (colour_updates_q.size() == 0) begin
                report($sformatf("unexpected result: ch %0d colour %0d busy %0d last %0d",
                                 got.channel, got.color, got.busy, got.last));
                return;
            end
            want = colour_updates_q.pop_front();
            if (got.channel !== want.channel || got.color !== want.color ||
                got.busy !== want.busy || got.last !== want.last) begin
                report($sformatf({"result mismatch: expected ch %0d colour %0d busy %0d",
                                  " last %0d, got ch %0d colour %0d busy %0d last %0d"},
                                 want.channel, want.color, want.busy, want.last,
                                 got.channel, got.color, got.busy, got.last));
            end
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [OP_W-1:0]    i_opcode      = '0;
    logic [IN_CH_W-1:0] i_channel     = '0;
    logic [COLOR_W-1:0] i_color_a     = '0;
    logic [DUR_W-1:0]   i_duration_a  = '0;
    logic [COLOR_W-1:0] i_color_b     = '0;
    logic [DUR_W-1:0]   i_duration_b  = '0;
    logic [DUR_W-1:0]   i_cycle_count = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [CH_W-1:0]    o_out_channel;
    logic [COLOR_W-1:0] o_out_color;
    logic               o_busy_res;
    logic               o_last;

    animator_scoreboard sb;
    int                 sender_idle_pct    = 0;
    int                 receiver_stall_pct = 0;
    int                 cycles_run         = 0;

    led_two_phase_animator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_channel     (i_channel),
        .i_color_a     (i_color_a),
        .i_duration_a  (i_duration_a),
        .i_color_b     (i_color_b),
        .i_duration_b  (i_duration_b),
        .i_cycle_count (i_cycle_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_channel (o_out_channel),
        .o_out_color   (o_out_color),
        .o_busy_res    (o_busy_res),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result({o_out_channel, o_out_color, o_busy_res, o_last});
        end
    end

    function automatic t_led_request make_request(t_op op, int ch, int ca, int da, int cb,
                                                  int db, int cyc);
        t_led_request req;
        req.op          = op;
        req.channel     = IN_CH_W'(ch);
        req.color_a     = COLOR_W'(ca);
        req.duration_a  = DUR_W'(da);
        req.color_b     = COLOR_W'(cb);
        req.duration_b  = DUR_W'(db);
        req.cycle_count = DUR_W'(cyc);
        return req;
    endfunction

    // Mostly short phases so that ticks keep the channels moving.
    function automatic logic [DUR_W-1:0] random_duration();
        int r;
        r = $urandom_range(99);
        if (r < 80) begin
            return DUR_W'($urandom_range(4));
        end else if (r < 90) begin
            return DUR_W'($urandom_range(20));
        end
        return DUR_W'($urandom_range(65535));
    endfunction

    function automatic t_led_request random_request();
        t_led_request req;
        int           r;
        r = $urandom_range(99);
        if (r < 40) begin
            req.op = OP_TICK;
        end else if (r < 65) begin
            req.op = OP_ANIM;
        end else if (r < 75) begin
            req.op = OP_SET;
        end else begin
            req.op = OP_QUERY;
        end
        if ($urandom_range(99) < 85) begin
            req.channel = IN_CH_W'($urandom_range(CHANNELS - 1));
        end else begin
            req.channel = IN_CH_W'($urandom_range(7, CHANNELS));
        end
        req.color_a    = COLOR_W'($urandom_range(7));
        req.color_b    = COLOR_W'($urandom_range(7));
        req.duration_a = random_duration();
        req.duration_b = random_duration();
        if ($urandom_range(99) < 70) begin
            req.cycle_count = DUR_W'($urandom_range(3));
        end else begin
            req.cycle_count = DUR_W'($urandom_range(65535));
        end
        return req;
    endfunction

    // Called at a falling edge; returns at a falling edge after the request
    // has been taken and any idle gap has passed.
    task automatic send_request(t_led_request req);
        i_in_valid    <= 1'b1;
        i_opcode      <= req.op;
        i_channel     <= req.channel;
        i_color_a     <= req.color_a;
        i_duration_a  <= req.duration_a;
        i_color_b     <= req.color_b;
        i_duration_b  <= req.duration_b;
        i_cycle_count <= req.cycle_count;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    initial begin
        t_led_request directed_q[$];
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_q.push_back(make_request(OP_QUERY, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_SET, 0, 7, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_SET, 3, 5, 65535, 7, 65535, 65535));
        directed_q.push_back(make_request(OP_SET, 5, 3, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_QUERY, 6, 7, 0, 7, 0, 0));
        directed_q.push_back(make_request(OP_TICK, 0, 0, 0, 0, 0, 0));
        // Both lengths zero: the colour is applied and the channel stops.
        directed_q.push_back(make_request(OP_ANIM, 1, 3, 0, 4, 0, 2));
        directed_q.push_back(make_request(OP_ANIM, 7, 1, 1, 2, 1, 0));
        directed_q.push_back(make_request(OP_ANIM, 0, 1, 1, 2, 2, 1));
        directed_q.push_back(make_request(OP_ANIM, 1, 7, 0, 6, 1, 0));
        directed_q.push_back(make_request(OP_ANIM, 2, 5, 1, 2, 65535, 65535));
        directed_q.push_back(make_request(OP_ANIM, 3, 1, 1, 2, 1, 0));
        // All four channels change on this tick.
        directed_q.push_back(make_request(OP_TICK, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_TICK, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_TICK, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_QUERY, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_QUERY, 2, 0, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_SET, 1, 0, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_TICK, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_QUERY, 1, 0, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_ANIM, 3, 0, 65535, 7, 0, 0));
        directed_q.push_back(make_request(OP_QUERY, 3, 0, 0, 0, 0, 0));
        directed_q.push_back(make_request(OP_QUERY, 4, 0, 0, 0, 0, 0));
        foreach (directed_q[k]) begin
            send_request(directed_q[k]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 71;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 71;
                end
                default: begin
                    sender_idle_pct    = 21;
                    receiver_stall_pct = 21;
                end
            endcase
            repeat (RANDOM_ITEMS) send_request(random_request());
        end

        i_in_valid         <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/tpa_pkg.sv
design/tpa_front.sv
design/tpa_back.sv
design/led_two_phase_animator.sv
dv/tb_led_two_phase_animator.sv
